[rtl/clrr_pkg.sv]
// Shared types, constants and LFSR helper functions of the combined LFSR range random block.
package clrr_pkg;

  // Field and register widths
  localparam int unsigned WIDE_W    = 32;
  localparam int unsigned NARROW_W  = 31;
  localparam int unsigned DRAW_W    = 16;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  // Default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Seed derivation constants
  localparam logic [31:0] SEED_OFFSET    = 32'h2F2F2F2F;
  localparam logic [31:0] WIDE_MOD       = 32'hFFFFFFFF;
  localparam logic [31:0] NARROW_MOD     = 32'h7FFFFFFF;
  localparam logic [31:0] NARROW_MOD_X2  = 32'hFFFFFFFE;

  // Reset values
  localparam logic [WIDE_W-1:0]   MASK_WIDE_RESET   = 32'hB4BCD35C;
  localparam logic [NARROW_W-1:0] MASK_NARROW_RESET = 31'h7A5BC2E3;
  localparam logic [WIDE_W-1:0]   WIDE_RESET        = 32'h00000001;
  localparam logic [NARROW_W-1:0] NARROW_RESET      = 31'h2F2F2F30;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED        = 2'd0,
    CFG_MASK_WIDE   = 2'd1,
    CFG_MASK_NARROW = 2'd2
  } cfg_index_t;

  // One queued request: draw, unsigned span and lower bound
  typedef struct packed {
    logic [DRAW_W-1:0]  draw;
    logic [VALUE_W-1:0] diff;
    logic [VALUE_W-1:0] low;
  } work_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  // One right-shifting Galois step of the wide register
  function automatic logic [WIDE_W-1:0] step_wide(input logic [WIDE_W-1:0] r,
                                                  input logic [WIDE_W-1:0] mask);
    logic [WIDE_W-1:0] s;
    s = r >> 1;
    if (r[0]) s = s ^ mask;
    return s;
  endfunction

  // One right-shifting Galois step of the narrow register
  function automatic logic [NARROW_W-1:0] step_narrow(input logic [NARROW_W-1:0] r,
                                                      input logic [NARROW_W-1:0] mask);
    logic [NARROW_W-1:0] s;
    s = r >> 1;
    if (r[0]) s = s ^ mask;
    return s;
  endfunction

  // seed mod 0xFFFFFFFF
  function automatic logic [WIDE_W-1:0] reload_wide(input logic [31:0] seed);
    return (seed == WIDE_MOD) ? '0 : seed;
  endfunction

  // ((seed + offset) mod 2^32) mod 0x7FFFFFFF; the 32-bit sum is below three times the modulus
  function automatic logic [NARROW_W-1:0] reload_narrow(input logic [31:0] seed);
    logic [31:0] s;
    s = seed + SEED_OFFSET;
    if (s >= NARROW_MOD_X2) s = s - NARROW_MOD_X2;
    else if (s >= NARROW_MOD) s = s - NARROW_MOD;
    return s[NARROW_W-1:0];
  endfunction

endpackage

[rtl/clrr_front.sv]
// Front end: configuration registers, both LFSRs, and request intake into the queue.
module clrr_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [clrr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clrr_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [63:0]                     s_tdata,   // range_low[31:0], range_high[63:32]
  input  clrr_pkg::q_status_t             q_status,
  output logic                            push,
  output clrr_pkg::work_t                 push_data
);

  logic [clrr_pkg::WIDE_W-1:0]   mask_wide;
  logic [clrr_pkg::NARROW_W-1:0] mask_narrow;
  logic [clrr_pkg::WIDE_W-1:0]   wide_reg;
  logic [clrr_pkg::NARROW_W-1:0] narrow_reg;
  logic [clrr_pkg::WIDE_W-1:0]   wide_reg_next;
  logic [clrr_pkg::NARROW_W-1:0] narrow_reg_next;
  logic [clrr_pkg::VALUE_W-1:0]  range_low;
  logic [clrr_pkg::VALUE_W-1:0]  range_high;

  assign range_low  = s_tdata[31:0];
  assign range_high = s_tdata[63:32];

  assign s_tready = !q_status.full;
  assign push     = s_tvalid && s_tready;

  // Wide register steps twice, narrow once per request
  always_comb begin
    wide_reg_next   = clrr_pkg::step_wide(clrr_pkg::step_wide(wide_reg, mask_wide), mask_wide);
    narrow_reg_next = clrr_pkg::step_narrow(narrow_reg, mask_narrow);
  end

  // Queue entry built from the stepped registers
  always_comb begin
    push_data.draw = wide_reg_next[clrr_pkg::DRAW_W-1:0]
                   ^ narrow_reg_next[clrr_pkg::DRAW_W-1:0];
    push_data.diff = range_high - range_low;
    push_data.low  = range_low;
  end

  // Configuration writes and LFSR advance
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_wide   <= clrr_pkg::MASK_WIDE_RESET;
      mask_narrow <= clrr_pkg::MASK_NARROW_RESET;
      wide_reg    <= clrr_pkg::WIDE_RESET;
      narrow_reg  <= clrr_pkg::NARROW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        clrr_pkg::CFG_SEED: begin
          wide_reg   <= clrr_pkg::reload_wide(cfg_data);
          narrow_reg <= clrr_pkg::reload_narrow(cfg_data);
        end
        clrr_pkg::CFG_MASK_WIDE: begin
          mask_wide <= cfg_data;
        end
        clrr_pkg::CFG_MASK_NARROW: begin
          mask_narrow <= cfg_data[clrr_pkg::NARROW_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (push) begin
      wide_reg   <= wide_reg_next;
      narrow_reg <= narrow_reg_next;
    end
  end

endmodule

[rtl/clrr_queue.sv]
// Short FIFO of pending requests between front and back.
module clrr_queue #(
  parameter int unsigned DEPTH = clrr_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  clrr_pkg::work_t     push_data,
  input  logic                pop,
  output clrr_pkg::work_t     pop_data,
  output clrr_pkg::q_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  clrr_pkg::work_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full      = (count == CNT_W'(DEPTH));
  assign status.not_empty = (count != '0);
  assign pop_data         = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full && !pop)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !status.not_empty)) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count beyond depth");

endmodule

[rtl/clrr_back.sv]
// Back end: bit-serial restoring modulo, bound add and output register.
module clrr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  clrr_pkg::q_status_t           q_status,
  input  clrr_pkg::work_t               q_data,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [clrr_pkg::VALUE_W-1:0]  m_tdata,   // value[31:0]
  output logic                          m_tuser    // empty_range[0]
);

  localparam int unsigned CNT_W = $clog2(clrr_pkg::DRAW_W);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                       state;
  state_t                       state_next;
  logic [clrr_pkg::DRAW_W-1:0]  draw_sh;
  logic [clrr_pkg::DRAW_W-1:0]  rem;
  logic [clrr_pkg::DRAW_W-1:0]  rem_next;
  logic [clrr_pkg::DRAW_W:0]    shifted;
  logic [clrr_pkg::VALUE_W-1:0] diff;
  logic [clrr_pkg::VALUE_W-1:0] low;
  logic [CNT_W-1:0]             count;
  logic                         out_free;

  assign out_free = !m_tvalid || m_tready;
  assign pop      = (state == ST_IDLE) && q_status.not_empty;

  // One restoring step: shift in next draw bit, subtract span if it fits
  always_comb begin
    shifted  = {rem, draw_sh[clrr_pkg::DRAW_W-1]};
    rem_next = shifted[clrr_pkg::DRAW_W-1:0];
    if ({{(clrr_pkg::VALUE_W-clrr_pkg::DRAW_W-1){1'b0}}, shifted} >= diff) begin
      rem_next = clrr_pkg::DRAW_W'(shifted - diff[clrr_pkg::DRAW_W:0]);
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (q_status.not_empty) state_next = ST_RUN;
      ST_RUN:    if (count == '0) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Datapath of the modulo unit
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        draw_sh <= q_data.draw;
        diff    <= q_data.diff;
        low     <= q_data.low;
        rem     <= '0;
        count   <= CNT_W'(clrr_pkg::DRAW_W - 1);
      end
      ST_RUN: begin
        rem     <= rem_next;
        draw_sh <= draw_sh << 1;
        count   <= count - 1'b1;
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Output register; empty span returns the lower bound
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      m_tuser <= (diff == '0);
      m_tdata <= (diff == '0) ? low
               : low + {{(clrr_pkg::VALUE_W-clrr_pkg::DRAW_W){1'b0}}, rem};
    end
  end

  // Checks
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && diff != '0) |=>
      ({{(clrr_pkg::VALUE_W-clrr_pkg::DRAW_W){1'b0}}, rem} < diff))
    else $error("remainder not below span");
  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !out_free) |=> (state == ST_FINISH))
    else $error("result dropped while output busy");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !pop) else $error("pop while modulo unit busy");

endmodule

[rtl/combined_lfsr_range_random_core.sv]
// Each word goes through the modulo unit in order: one load, 16 restoring steps, one result write.
// The bit-serial modulo loop sets the sustained rate: a new word is taken only after the last is written out.
// The request queue lets the front accept while the back end and output register are busy.
// rst is synchronous, active high: LFSRs reload from seed 1, masks take their defaults,
// queue and output are emptied.
module combined_lfsr_range_random_core #(
  parameter int unsigned QUEUE_DEPTH = clrr_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [clrr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clrr_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [63:0]                     s_tdata,   // range_low[31:0], range_high[63:32]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [clrr_pkg::VALUE_W-1:0]    m_tdata,   // value[31:0]
  output logic                            m_tuser    // empty_range[0]
);

  clrr_pkg::q_status_t q_status;
  clrr_pkg::work_t     push_data;
  clrr_pkg::work_t     pop_data;
  logic                push;
  logic                pop;

  clrr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  clrr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  clrr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_data   (pop_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
